[design/pvta_pkg.sv]
// shared constants and step-angle table for the vertex turn angle pipeline
package pvta_pkg;

  // parameter defaults
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned COORD_WIDTH_DEF   = 32;

  // cordic iteration limit, matches the size of the step-angle table
  localparam int unsigned MAX_ITERATIONS = 32;

  // vector scaling: larger component magnitude lands with its top bit here
  localparam int unsigned NORM_MSB = 28;
  localparam int unsigned SCALED_W = 31;
  localparam int unsigned EXT_W    = 64;

  // product, cordic datapath and angle accumulator widths
  localparam int unsigned PROD_W  = 2 * SCALED_W;
  localparam int unsigned ACC_W   = 64;
  localparam int unsigned Z_W     = 25;
  localparam int unsigned ANGLE_W = 15;
  localparam int unsigned STEP_W  = 22;

  // scaled components lie within plus or minus this bound
  localparam logic signed [SCALED_W-1:0] SCALE_LIM = 31'sd536870912;

  // 90 degrees in Q7.8
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 15'd23040;

  // rounding offset for the Q.16 to Q.8 step
  localparam logic signed [Z_W:0] ROUND_HALF = 26'sd128;

  // atan(2^-i) in degrees, Q.16, rounded to nearest
  localparam logic [STEP_W-1:0] STEP_ANGLE [MAX_ITERATIONS] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,
    22'd57,      22'd29,      22'd14,     22'd7,
    22'd4,       22'd2,       22'd1,      22'd0,
    22'd0,       22'd0,       22'd0,      22'd0,
    22'd0,       22'd0,       22'd0,      22'd0
  };

endpackage

[design/polyline_vertex_turn_angle.sv]
// vertex turn angle: folded angle between two polyline segments, pipelined cordic
//
//  channel   ports                                        direction  handshake
//  request   start_x_i start_y_i vertex_x_i vertex_y_i    in         start_i high, busy_o low
//            end_x_i end_y_i
//  result    angle_deg_o degenerate_o                     out        done_o, one cycle
//
// one request may enter every cycle; busy_o stays low, the pipeline never stalls
// the pipeline has seven front stages (difference, magnitude, leading one,
// scaling, products, cross and dot sums, absolute values), one register per
// cordic iteration and the output register
// the receiver cannot hold results off, so each result shows for exactly one cycle
// reset clears only the valid bits; data registers carry over and are ignored
module polyline_vertex_turn_angle #(
  parameter int unsigned CORDIC_STAGES = pvta_pkg::CORDIC_STAGES_DEF,
  parameter int unsigned COORD_WIDTH   = pvta_pkg::COORD_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [COORD_WIDTH-1:0]        start_x_i,
  input  logic signed [COORD_WIDTH-1:0]        start_y_i,
  input  logic signed [COORD_WIDTH-1:0]        vertex_x_i,
  input  logic signed [COORD_WIDTH-1:0]        vertex_y_i,
  input  logic signed [COORD_WIDTH-1:0]        end_x_i,
  input  logic signed [COORD_WIDTH-1:0]        end_y_i,
  output logic                                 done_o,
  output logic        [pvta_pkg::ANGLE_W-1:0]  angle_deg_o,
  output logic                                 degenerate_o
);
  import pvta_pkg::*;

  localparam int unsigned DIFF_W = COORD_WIDTH + 1;
  localparam int unsigned TOP_W  = $clog2(DIFF_W);
  localparam int unsigned NUM_IT =
    (CORDIC_STAGES > MAX_ITERATIONS) ? MAX_ITERATIONS : CORDIC_STAGES;

  // shift of a difference so the vector's leading one (top) sits at NORM_MSB
  function automatic logic signed [SCALED_W-1:0] scale_comp(
    input logic signed [DIFF_W-1:0] v,
    input logic        [TOP_W-1:0]  top
  );
    logic signed [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    if (int'(top) > int'(NORM_MSB)) begin
      ext = ext >>> (int'(top) - int'(NORM_MSB));
    end else begin
      ext = ext << (int'(NORM_MSB) - int'(top));
    end
    return ext[SCALED_W-1:0];
  endfunction

  // the pipeline always flows
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------- stage 1
  // vertex-relative vectors and zero-length detection
  logic                     v1_q;
  logic signed [DIFF_W-1:0] ax1_d, ay1_d, bx1_d, by1_d;
  logic signed [DIFF_W-1:0] ax1_q, ay1_q, bx1_q, by1_q;
  logic                     dg1_d, dg1_q;

  always_comb begin
    ax1_d = DIFF_W'(start_x_i) - DIFF_W'(vertex_x_i);
    ay1_d = DIFF_W'(start_y_i) - DIFF_W'(vertex_y_i);
    bx1_d = DIFF_W'(end_x_i)   - DIFF_W'(vertex_x_i);
    by1_d = DIFF_W'(end_y_i)   - DIFF_W'(vertex_y_i);
    dg1_d = ((ax1_d == '0) && (ay1_d == '0)) || ((bx1_d == '0) && (by1_d == '0));
  end

  always_ff @(posedge clk_i) begin
    ax1_q <= ax1_d;
    ay1_q <= ay1_d;
    bx1_q <= bx1_d;
    by1_q <= by1_d;
    dg1_q <= dg1_d;
  end

  // ---------------------------------------------------------------- stage 2
  // or of component magnitudes per vector
  logic                     v2_q;
  logic        [DIFF_W-1:0] ma2_d, mb2_d, ma2_q, mb2_q;
  logic signed [DIFF_W-1:0] ax2_q, ay2_q, bx2_q, by2_q;
  logic                     dg2_q;

  always_comb begin
    ma2_d = (ax1_q[DIFF_W-1] ? DIFF_W'(-ax1_q) : DIFF_W'(ax1_q)) |
            (ay1_q[DIFF_W-1] ? DIFF_W'(-ay1_q) : DIFF_W'(ay1_q));
    mb2_d = (bx1_q[DIFF_W-1] ? DIFF_W'(-bx1_q) : DIFF_W'(bx1_q)) |
            (by1_q[DIFF_W-1] ? DIFF_W'(-by1_q) : DIFF_W'(by1_q));
  end

  always_ff @(posedge clk_i) begin
    ma2_q <= ma2_d;
    mb2_q <= mb2_d;
    ax2_q <= ax1_q;
    ay2_q <= ay1_q;
    bx2_q <= bx1_q;
    by2_q <= by1_q;
    dg2_q <= dg1_q;
  end

  // ---------------------------------------------------------------- stage 3
  // leading one position of each magnitude
  logic                     v3_q;
  logic        [TOP_W-1:0]  ta3_d, tb3_d, ta3_q, tb3_q;
  logic signed [DIFF_W-1:0] ax3_q, ay3_q, bx3_q, by3_q;
  logic                     dg3_q;

  always_comb begin
    ta3_d = '0;
    tb3_d = '0;
    for (int i = 0; i < int'(DIFF_W); i++) begin
      if (ma2_q[i]) begin
        ta3_d = TOP_W'(i);
      end
      if (mb2_q[i]) begin
        tb3_d = TOP_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ta3_q <= ta3_d;
    tb3_q <= tb3_d;
    ax3_q <= ax2_q;
    ay3_q <= ay2_q;
    bx3_q <= bx2_q;
    by3_q <= by2_q;
    dg3_q <= dg2_q;
  end

  // ---------------------------------------------------------------- stage 4
  // per-vector power of two scaling
  logic                       v4_q;
  logic signed [SCALED_W-1:0] ax4_d, ay4_d, bx4_d, by4_d;
  logic signed [SCALED_W-1:0] ax4_q, ay4_q, bx4_q, by4_q;
  logic                       dg4_q;

  always_comb begin
    ax4_d = scale_comp(ax3_q, ta3_q);
    ay4_d = scale_comp(ay3_q, ta3_q);
    bx4_d = scale_comp(bx3_q, tb3_q);
    by4_d = scale_comp(by3_q, tb3_q);
  end

  always_ff @(posedge clk_i) begin
    ax4_q <= ax4_d;
    ay4_q <= ay4_d;
    bx4_q <= bx4_d;
    by4_q <= by4_d;
    dg4_q <= dg3_q;
  end

  // ---------------------------------------------------------------- stage 5
  // the four partial products
  logic                     v5_q;
  logic signed [PROD_W-1:0] p_axby_d, p_aybx_d, p_axbx_d, p_ayby_d;
  logic signed [PROD_W-1:0] p_axby_q, p_aybx_q, p_axbx_q, p_ayby_q;
  logic                     dg5_q;

  always_comb begin
    p_axby_d = PROD_W'(ax4_q) * PROD_W'(by4_q);
    p_aybx_d = PROD_W'(ay4_q) * PROD_W'(bx4_q);
    p_axbx_d = PROD_W'(ax4_q) * PROD_W'(bx4_q);
    p_ayby_d = PROD_W'(ay4_q) * PROD_W'(by4_q);
  end

  always_ff @(posedge clk_i) begin
    p_axby_q <= p_axby_d;
    p_aybx_q <= p_aybx_d;
    p_axbx_q <= p_axbx_d;
    p_ayby_q <= p_ayby_d;
    dg5_q    <= dg4_q;
  end

  // ---------------------------------------------------------------- stage 6
  // cross and dot products
  logic                    v6_q;
  logic signed [ACC_W-1:0] cross6_d, dot6_d, cross6_q, dot6_q;
  logic                    dg6_q;

  always_comb begin
    cross6_d = ACC_W'(p_axby_q) - ACC_W'(p_aybx_q);
    dot6_d   = ACC_W'(p_axbx_q) + ACC_W'(p_ayby_q);
  end

  always_ff @(posedge clk_i) begin
    cross6_q <= cross6_d;
    dot6_q   <= dot6_d;
    dg6_q    <= dg5_q;
  end

  // ---------------------------------------------------------------- cordic
  // entry 0 holds |dot| and |cross|, entry i+1 the result of iteration i
  logic                    cv_q [NUM_IT+1];
  logic                    cd_q [NUM_IT+1];
  logic signed [ACC_W-1:0] cx_q [NUM_IT+1];
  logic signed [ACC_W-1:0] cy_q [NUM_IT+1];
  logic signed [Z_W-1:0]   cz_q [NUM_IT+1];

  // stage 7: absolute values into the cordic
  always_ff @(posedge clk_i) begin
    cx_q[0] <= dot6_q[ACC_W-1]   ? -dot6_q   : dot6_q;
    cy_q[0] <= cross6_q[ACC_W-1] ? -cross6_q : cross6_q;
    cz_q[0] <= '0;
    cd_q[0] <= dg6_q;
  end

  // one vectoring iteration per register stage
  for (genvar gi = 0; gi < NUM_IT; gi++) begin : g_iter
    logic signed [ACC_W-1:0] x_d, y_d;
    logic signed [Z_W-1:0]   z_d;

    always_comb begin
      if (!cy_q[gi][ACC_W-1]) begin
        x_d = cx_q[gi] + (cy_q[gi] >>> gi);
        y_d = cy_q[gi] - (cx_q[gi] >>> gi);
        z_d = cz_q[gi] + Z_W'(STEP_ANGLE[gi]);
      end else begin
        x_d = cx_q[gi] - (cy_q[gi] >>> gi);
        y_d = cy_q[gi] + (cx_q[gi] >>> gi);
        z_d = cz_q[gi] - Z_W'(STEP_ANGLE[gi]);
      end
    end

    always_ff @(posedge clk_i) begin
      cx_q[gi+1] <= x_d;
      cy_q[gi+1] <= y_d;
      cz_q[gi+1] <= z_d;
      cd_q[gi+1] <= cd_q[gi];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[gi+1] <= 1'b0;
      end else begin
        cv_q[gi+1] <= cv_q[gi];
      end
    end
  end

  // ---------------------------------------------------------------- output
  // round to Q.8, clamp to 0..90 degrees, force 0 for a zero-length vector
  logic signed [Z_W:0]    rnd;
  logic [ANGLE_W-1:0]     angle_d, angle_q;
  logic                   degen_q, done_q;

  always_comb begin
    rnd = (Z_W+1)'(cz_q[NUM_IT]) + ROUND_HALF;
    rnd = rnd >>> 8;
    if (cd_q[NUM_IT] || cz_q[NUM_IT][Z_W-1]) begin
      angle_d = '0;
    end else if (rnd > $signed({1'b0, ANGLE_MAX})) begin
      angle_d = ANGLE_MAX;
    end else begin
      angle_d = rnd[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
    degen_q <= cd_q[NUM_IT];
  end

  // valid bits of the front stages and the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      cv_q[0] <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      v1_q    <= start_i && !busy_o;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      v6_q    <= v5_q;
      cv_q[0] <= v6_q;
      done_q  <= cv_q[NUM_IT];
    end
  end

  assign done_o       = done_q;
  assign angle_deg_o  = angle_q;
  assign degenerate_o = degen_q;

  // ---------------------------------------------------------------- checks
  // a degenerate request always reports a zero angle
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && degen_q |-> angle_q == '0)
    else $error("degenerate result with nonzero angle");

  // the folded angle never passes 90 degrees
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> angle_q <= ANGLE_MAX)
    else $error("angle above 90 degrees");

  // scaling keeps the a-vector x and b-vector y components within the product range
  a_scaled_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q && !dg5_q |-> $past(ax4_q) <= SCALE_LIM && $past(ax4_q) >= -SCALE_LIM &&
                       $past(by4_q) <= SCALE_LIM && $past(by4_q) >= -SCALE_LIM)
    else $error("scaled component out of range");

  // cordic starts from a non-negative vector in the first quadrant
  a_cordic_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv_q[0] |-> !cx_q[0][ACC_W-1] && !cy_q[0][ACC_W-1])
    else $error("cordic input not in first quadrant");

endmodule

[tb/testbench.sv]
// testbench for the vertex turn angle pipeline: random and directed requests, scoreboard check
module testbench;

  localparam int unsigned CORDIC_STAGES = pvta_pkg::CORDIC_STAGES_DEF;
  localparam int unsigned COORD_WIDTH   = pvta_pkg::COORD_WIDTH_DEF;
  localparam int unsigned LATENCY       = CORDIC_STAGES + 8;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned RANDOM_ITEMS  = 1550;
  localparam int unsigned ANGLE_CEIL    = 23040;
  localparam int unsigned NORM_TOP      = 28;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // atan(2^-i) in degrees, Q.16
  localparam int TURN_STEP_Q16 [32] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic [pvta_pkg::ANGLE_W-1:0] angle;
    logic                         degenerate;
  } turn_result_t;

  // expected turn angles in request order, checked against each strobed result
  class turn_angle_scoreboard;
    turn_result_t expected_turns[$];
    int unsigned  mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    // bring the larger component magnitude to the normalisation bit
    function void scale_vector(inout logic signed [63:0] vx, inout logic signed [63:0] vy);
      logic [63:0] mag;
      int          top;
      mag = (vx < 0 ? -vx : vx) | (vy < 0 ? -vy : vy);
      top = 63;
      while (top > 0 && !mag[top]) top--;
      if (top > NORM_TOP) begin
        vx = vx >>> (top - NORM_TOP);
        vy = vy >>> (top - NORM_TOP);
      end else begin
        vx = vx << (NORM_TOP - top);
        vy = vy << (NORM_TOP - top);
      end
    endfunction

    // folded angle between vertex->start and vertex->end
    function turn_result_t predict_turn(coord_t sx, coord_t sy, coord_t vx, coord_t vy,
                                        coord_t ex, coord_t ey);
      logic signed [63:0] ax, ay, bx, by, cross_p, dot_p, yv;
      logic [63:0]        xv, xs, ys;
      int                 z, q;
      turn_result_t       res;
      res = '0;
      ax = sx; ay = sy; bx = ex; by = ey;
      ax = ax - vx; ay = ay - vy;
      bx = bx - vx; by = by - vy;
      if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) begin
        res.degenerate = 1'b1;
        return res;
      end
      scale_vector(ax, ay);
      scale_vector(bx, by);
      cross_p = ax * by - ay * bx;
      dot_p   = ax * bx + ay * by;
      xv = dot_p < 0 ? -dot_p : dot_p;
      yv = cross_p < 0 ? -cross_p : cross_p;
      z  = 0;
      // vectoring iterations, y driven towards zero
      for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
        xs = xv >> i;
        ys = yv >>> i;
        if (!yv[63]) begin
          xv = xv + ys;
          yv = yv - xs;
          z  = z + TURN_STEP_Q16[i];
        end else begin
          xv = xv - ys;
          yv = yv + xs;
          z  = z - TURN_STEP_Q16[i];
        end
      end
      if (z < 0) q = 0;
      else q = (z + 128) >>> 8;
      if (q > ANGLE_CEIL) q = ANGLE_CEIL;
      res.angle = q[pvta_pkg::ANGLE_W-1:0];
      return res;
    endfunction

    function void note_request(coord_t sx, coord_t sy, coord_t vx, coord_t vy,
                               coord_t ex, coord_t ey);
      expected_turns.insert(expected_turns.size(), predict_turn(sx, sy, vx, vy, ex, ey));
    endfunction

    function void check_result(logic [pvta_pkg::ANGLE_W-1:0] angle, logic degenerate);
      turn_result_t want;
      if (expected_turns.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: angle %0d degenerate %0b", angle, degenerate);
        return;
      end
      want = expected_turns.pop_front();
      if (angle !== want.angle || degenerate !== want.degenerate) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("mismatch: angle exp %0d got %0d, degenerate exp %0b got %0b",
                   want.angle, angle, want.degenerate, degenerate);
      end
    endfunction

    function int unsigned pending();
      return expected_turns.size();
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start_i = 1'b0;
  logic                         busy_o;
  coord_t                       start_x_i = '0;
  coord_t                       start_y_i = '0;
  coord_t                       vertex_x_i = '0;
  coord_t                       vertex_y_i = '0;
  coord_t                       end_x_i = '0;
  coord_t                       end_y_i = '0;
  logic                         done_o;
  logic [pvta_pkg::ANGLE_W-1:0] angle_deg_o;
  logic                         degenerate_o;

  turn_angle_scoreboard sb = new();
  bit                   idle_on = 1'b1;

  polyline_vertex_turn_angle #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .vertex_x_i  (vertex_x_i),
    .vertex_y_i  (vertex_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .done_o      (done_o),
    .angle_deg_o (angle_deg_o),
    .degenerate_o(degenerate_o)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // watch both handshakes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o)
        sb.note_request(start_x_i, start_y_i, vertex_x_i, vertex_y_i, end_x_i, end_y_i);
      if (done_o) sb.check_result(angle_deg_o, degenerate_o);
    end
  end

  // one request, with random idle cycles ahead of it
  task automatic send_request(coord_t sx, coord_t sy, coord_t vx, coord_t vy,
                              coord_t ex, coord_t ey);
    while (idle_on && $urandom_range(99) < 28) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_x_i  <= sx;
    start_y_i  <= sy;
    vertex_x_i <= vx;
    vertex_y_i <= vy;
    end_x_i    <= ex;
    end_y_i    <= ey;
    start_i    <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // random request drawn from a mix of shapes
  task automatic send_random_request();
    coord_t vx, vy, ax, ay, bx, by;
    int     mode, k;
    mode = $urandom_range(99);
    vx = $urandom;
    vy = $urandom;
    ax = $signed($urandom) >>> $urandom_range(31);
    ay = $signed($urandom) >>> $urandom_range(31);
    bx = $signed($urandom) >>> $urandom_range(31);
    by = $signed($urandom) >>> $urandom_range(31);
    if (mode < 15) begin
      // unrelated full-range points
      send_request($urandom, $urandom, vx, vy, $urandom, $urandom);
    end else if (mode < 50) begin
      // offsets of random size around the vertex, wrapping allowed
      send_request(vx + ax, vy + ay, vx, vy, vx + bx, vy + by);
    end else if (mode < 80) begin
      // collinear or perpendicular pairs, kept clear of wrapping
      vx = vx >>> 4;
      vy = vy >>> 4;
      ax = $signed($urandom) >>> 20;
      ay = $signed($urandom) >>> 20;
      k  = $signed($urandom) >>> 20;
      if (k == 0) k = 1;
      if (mode < 65) begin
        bx = ax * k;
        by = ay * k;
      end else begin
        bx = -ay * k;
        by = ax * k;
      end
      send_request(vx + ax, vy + ay, vx, vy, vx + bx, vy + by);
    end else if (mode < 85) begin
      // zero-length leg on one or both sides
      k = $urandom_range(2);
      if (k != 1) begin ax = '0; ay = '0; end
      if (k != 0) begin bx = '0; by = '0; end
      send_request(vx + ax, vy + ay, vx, vy, vx + bx, vy + by);
    end else begin
      // short legs of a few units
      ax = $urandom_range(16); ax = ax - 8;
      ay = $urandom_range(16); ay = ay - 8;
      bx = $urandom_range(16); bx = bx - 8;
      by = $urandom_range(16); by = by - 8;
      send_request(vx + ax, vy + ay, vx, vy, vx + bx, vy + by);
    end
  endtask

  // main sequence
  initial begin
    int unsigned waited;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed corners
    send_request(0, 0, 0, 0, 0, 0);
    send_request(7, -3, 7, -3, 100, 50);
    send_request(COORD_MIN, 5, -4, 9, -4, 9);
    send_request(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN);
    send_request(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX);
    send_request(COORD_MIN, 0, COORD_MAX, 0, 0, COORD_MIN);
    send_request(1, 0, 0, 0, 5, 0);
    send_request(1, 0, 0, 0, -3, 0);
    send_request(1, 0, 0, 0, 0, 1);
    send_request(COORD_MAX, 0, 0, 0, 0, COORD_MIN);
    send_request(1, 0, 0, 0, 1, 1);
    send_request(1, 0, 0, 0, -1, 1);
    send_request(32'sh40000000, 0, 0, 0, 32'sh40000000, 1);
    send_request(32'sh40000000, 1, 0, 0, 0, 32'sh40000000);
    send_request(32'sh55555555, 32'shAAAAAAAA, 32'shAAAAAAAA, 32'sh55555555,
                 32'sh55555555, 32'sh55555555);
    send_request(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX - 1, COORD_MAX - 1, COORD_MAX);
    send_request(COORD_MIN + 1, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN + 1);
    send_request(-1, -1, 0, 0, 1, 1);
    send_request(3, 4, 0, 0, -4, 3);
    send_request(0, COORD_MAX, 0, COORD_MIN, COORD_MAX, COORD_MAX);

    // random part, with a long stretch at full rate
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on = !(n >= 600 && n < 900);
      send_random_request();
    end
    @(negedge clk_i);
    start_i <= 1'b0;

    // drain the pipeline
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (LATENCY + 4) @(posedge clk_i);

    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

[filelist.f]
design/pvta_pkg.sv
design/polyline_vertex_turn_angle.sv
tb/testbench.sv
